### src/cas_pkg.sv
// shared constants, types and helpers for the cave smoothing stream
package cas_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COORD_W = 10;
  localparam int SIZE_W  = 11;
  localparam int ADDR_W  = $clog2(MAX_WIDTH);

  localparam logic [SIZE_W-1:0] MIN_SIZE     = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] RESET_SIZE   = SIZE_W'(64);
  localparam logic [SIZE_W-1:0] WIDTH_LIMIT  = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] HEIGHT_LIMIT = SIZE_W'(MAX_HEIGHT);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam int NB_W = 4;
  localparam logic [NB_W-1:0] NB_KEEP = NB_W'(4);

  localparam int SLOTS = 3;
  localparam int CNT_W = 2;

  typedef struct packed {
    logic               wall;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last_col;
    logic               last_row;
  } stage_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               wall;
    logic               last;
  } result_t;

  typedef struct packed {
    result_t [SLOTS-1:0] slot;
    logic [CNT_W-1:0]    cnt;
  } bundle_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] limit);
    logic [SIZE_W-1:0] r;
    if (v < MIN_SIZE) r = MIN_SIZE;
    else if (v > limit) r = limit;
    else r = v;
    return r;
  endfunction

  function automatic result_t make_result(input logic [COORD_W-1:0] x,
                                          input logic [COORD_W-1:0] y,
                                          input logic wall, input logic last);
    result_t r;
    r.x    = x;
    r.y    = y;
    r.wall = wall;
    r.last = last;
    return r;
  endfunction

endpackage

### src/cas_ram.sv
// generic single-bit-or-wider ram, one write and one registered read port
module cas_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/cas_raster.sv
// size registers, raster counters and the input register stage
module cas_raster import cas_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  logic                 accept,
  input  logic                 cell_in,
  input  logic                 fire,
  output logic [ADDR_W-1:0]    rd_addr,
  output logic                 s1_valid,
  output stage_t               s1
);

  logic [SIZE_W-1:0]  grid_width;
  logic [SIZE_W-1:0]  grid_height;
  logic [COORD_W-1:0] column_count;
  logic [COORD_W-1:0] row_count;
  logic [COORD_W-1:0] column_count_next;
  logic [COORD_W-1:0] row_count_next;
  logic [SIZE_W-1:0]  w_eff;
  logic [SIZE_W-1:0]  h_eff;
  logic [COORD_W-1:0] x;
  logic [COORD_W-1:0] y;
  logic               last_col;
  logic               last_row;
  logic               s1_valid_next;

  always_comb begin
    w_eff    = clamp_size(grid_width, WIDTH_LIMIT);
    h_eff    = clamp_size(grid_height, HEIGHT_LIMIT);
    x        = ({1'b0, column_count} >= w_eff) ? '0 : column_count;
    y        = ({1'b0, row_count} >= h_eff) ? '0 : row_count;
    last_col = ({1'b0, x} + SIZE_W'(1)) >= w_eff;
    last_row = ({1'b0, y} + SIZE_W'(1)) >= h_eff;
    rd_addr  = x[ADDR_W-1:0];

    column_count_next = column_count;
    row_count_next    = row_count;
    if (accept) begin
      if (last_col) begin
        column_count_next = '0;
        row_count_next    = last_row ? '0 : y + COORD_W'(1);
      end else begin
        column_count_next = x + COORD_W'(1);
        row_count_next    = y;
      end
    end

    s1_valid_next = s1_valid;
    if (accept) begin
      s1_valid_next = 1'b1;
    end else if (fire) begin
      s1_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= RESET_SIZE;
      grid_height  <= RESET_SIZE;
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_WIDTH:  grid_width  <= cfg_data;
          REG_GRID_HEIGHT: grid_height <= cfg_data;
          default: ;
        endcase
      end
      column_count <= column_count_next;
      row_count    <= row_count_next;
      s1_valid     <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.wall     <= cell_in;
      s1.x        <= x;
      s1.y        <= y;
      s1.last_col <= last_col;
      s1.last_row <= last_row;
    end
  end

endmodule

### src/cas_window.sv
// 3x3 window register, 4-5 neighbour rule and per-cell result list
module cas_window import cas_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  stage_t  s1,
  input  logic    top_bit,
  input  logic    mid_bit,
  output bundle_t bundle
);

  logic [8:0]         window_bits;
  logic [8:0]         window_bits_next;
  logic [NB_W-1:0]    nb;
  logic               smoothed;
  logic [COORD_W-1:0] y_up;
  logic [CNT_W-1:0]   n;

  function automatic logic [2:0] cell_row(input logic [2:0] row, input logic b);
    return {b, row[2:1]};
  endfunction

  always_comb begin
    // each row shifts toward bit 0, newest column enters at the top bit
    window_bits_next = {cell_row(window_bits[8:6], s1.wall),
                        cell_row(window_bits[5:3], mid_bit),
                        cell_row(window_bits[2:0], top_bit)};
    nb = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        nb = nb + NB_W'(window_bits_next[i]);
      end
    end
    if (nb > NB_KEEP) smoothed = 1'b1;
    else if (nb < NB_KEEP) smoothed = 1'b0;
    else smoothed = window_bits_next[4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= '0;
    end else if (fire) begin
      window_bits <= window_bits_next;
    end
  end

  always_comb begin
    y_up   = s1.y - COORD_W'(1);
    n      = '0;
    bundle = '0;
    if (s1.y == '0) begin
      bundle.slot[0] = make_result(s1.x, '0, 1'b1, 1'b0);
      n = CNT_W'(1);
    end else if (s1.y != COORD_W'(1)) begin
      // row above is now complete up to column x-1
      if (s1.x == '0) begin
        bundle.slot[n] = make_result('0, y_up, 1'b1, 1'b0);
        n = n + CNT_W'(1);
      end else if (s1.x != COORD_W'(1)) begin
        bundle.slot[n] = make_result(s1.x - COORD_W'(1), y_up, smoothed, 1'b0);
        n = n + CNT_W'(1);
      end
      if (s1.last_col) begin
        bundle.slot[n] = make_result(s1.x, y_up, 1'b1, 1'b0);
        n = n + CNT_W'(1);
      end
      if (s1.last_row) begin
        bundle.slot[n] = make_result(s1.x, s1.y, 1'b1, s1.last_col);
        n = n + CNT_W'(1);
      end
    end
    bundle.cnt = n;
  end

endmodule

### src/cas_emit.sv
// result register that hands out one result of the current cell per transfer
module cas_emit import cas_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  bundle_t            bundle,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [COORD_W-1:0] out_x,
  output logic [COORD_W-1:0] out_y,
  output logic               cell_out,
  output logic               frame_last,
  output logic               free
);

  result_t [SLOTS-1:0] slot;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    idx;
  result_t             head;

  always_comb begin
    out_valid = idx < cnt;
    free      = !out_valid || (!out_stall && (idx + CNT_W'(1) == cnt));
    case (idx)
      CNT_W'(1): head = slot[1];
      CNT_W'(2): head = slot[2];
      default:   head = slot[0];
    endcase
    out_x      = head.x;
    out_y      = head.y;
    cell_out   = head.wall;
    frame_last = head.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (load) begin
      cnt <= bundle.cnt;
      idx <= '0;
    end else if (out_valid && !out_stall) begin
      idx <= idx + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= bundle.slot;
    end
  end

endmodule

### src/cellular_automaton_smoothing.sv
// top level of the streaming cave smoothing pass (4-5 rule)
//
// cells enter on cell_in in row-major order, one per transfer on in_valid/in_stall.
// smoothed cells leave on out_x/out_y/cell_out/frame_last, one per transfer on
// out_valid/out_stall; frame_last marks the bottom-right cell, and the next cell
// transferred in starts a new pass over the grid.
// grid_width (index 0) and grid_height (index 1) are written on cfg_we; the user
// writes them only while the block is idle, which the block does not enforce.
// values outside 3..1024 act as the nearest bound. reset gives 64. a cell taken
// in waits in the input register until the result register is free to take its
// results. row 0 gives its result with each cell, row 1 gives none, lower rows
// give the cell one row up and one column back; the last column and the bottom
// row add border results. the result register hands out one result per cycle
// while out_stall is low and takes in the next cell's results as the last result
// of the current one is transferred. from row 2 on, a cell gives two results at
// the end of a row and along the bottom row but for its second column, three at
// the bottom-right corner. the two line buffers are single-bit rams read when a
// cell is taken in. reset clears counters, window and result register; the rams
// need no clearing. while out_stall is high the result holds and in_stall rises
// once the input register is also full.
module cellular_automaton_smoothing import cas_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cell_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [COORD_W-1:0]   out_x,
  output logic [COORD_W-1:0]   out_y,
  output logic                 cell_out,
  output logic                 frame_last
);

  logic              accept;
  logic              fire;
  logic              free;
  logic              s1_valid;
  stage_t            s1;
  logic [ADDR_W-1:0] rd_addr;
  logic              top_bit;
  logic              mid_bit;
  bundle_t           bundle;

  assign fire     = s1_valid && free;
  assign in_stall = s1_valid && !free;
  assign accept   = in_valid && !in_stall;

  cas_raster u_raster (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .cell_in   (cell_in),
    .fire      (fire),
    .rd_addr   (rd_addr),
    .s1_valid  (s1_valid),
    .s1        (s1)
  );

  // row y-2
  cas_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_row_older (
    .clk   (clk),
    .we    (fire),
    .waddr (s1.x[ADDR_W-1:0]),
    .wdata (mid_bit),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (top_bit)
  );

  // row y-1
  cas_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_row_newer (
    .clk   (clk),
    .we    (fire),
    .waddr (s1.x[ADDR_W-1:0]),
    .wdata (s1.wall),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (mid_bit)
  );

  cas_window u_window (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .s1      (s1),
    .top_bit (top_bit),
    .mid_bit (mid_bit),
    .bundle  (bundle)
  );

  cas_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .bundle     (bundle),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_x      (out_x),
    .out_y      (out_y),
    .cell_out   (cell_out),
    .frame_last (frame_last),
    .free       (free)
  );

endmodule

### src/cas_checker.sv
// port-level checks for the cave smoothing stream, bound to the top level
module cas_checker import cas_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [COORD_W-1:0] out_x,
  input logic [COORD_W-1:0] out_y,
  input logic               cell_out,
  input logic               frame_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(cell_out) && $stable(frame_last))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

  a_last_is_wall: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> cell_out)
    else $error("final cell of the pass is not a wall");

  a_border_is_wall: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_x == '0 || out_y == '0) |-> cell_out)
    else $error("left or top border cell is not a wall");

endmodule

bind cellular_automaton_smoothing cas_checker u_cas_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_x      (out_x),
  .out_y      (out_y),
  .cell_out   (cell_out),
  .frame_last (frame_last)
);
